### rtl/absrc_pkg.sv
// Shared types and constants of the A/B snapshot record checker.
// Used by absrc_front, absrc_queue, absrc_back and the top level.
`timescale 1ns / 1ps

package absrc_pkg;

   localparam int COUNT_W             = 13;
   localparam int HEADER_BYTES        = 16;
   localparam int MAX_PAYLOAD_DEFAULT = 4096;
   localparam int QUEUE_DEPTH         = 2;
   localparam int REQ_DATA_W          = 8;
   localparam int REQ_USER_W          = 2;
   localparam int RSP_DATA_W          = 72;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [31:0]        CRC_POLY  = 32'hedb88320;
   localparam logic [31:0]        CRC_INIT  = 32'hffffffff;

   // Magic "I3TX" in stream order, first byte at index 0.
   localparam logic [3:0][7:0] MAGIC = {8'h58, 8'h54, 8'h33, 8'h49};

   localparam logic CMD_RECORD  = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // One finished record, or a restart, as handed from front to back.
   typedef struct packed {
      logic               is_restart;
      logic               slot;
      logic               magic_ok;
      logic [COUNT_W-1:0] total;
      logic [31:0]        hdr_gen;
      logic [31:0]        hdr_len;
      logic [31:0]        hdr_crc;
      logic [31:0]        crc;
   } rec_entry_type;

endpackage

### rtl/absrc_front.sv
// Front end: accepts record words, captures the header and runs the CRC-32.
// Hands one absrc_pkg::rec_entry_type per last byte or restart to the queue.
`timescale 1ns / 1ps

module absrc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      cmd,
   input  logic [7:0]                data_byte,
   input  logic                      slot_select,
   input  logic                      last_byte,
   output logic                      push,
   output absrc_pkg::rec_entry_type  entry
);

   logic [absrc_pkg::COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [31:0] crc_ff, crc_in;
   logic        magic_ok_ff, magic_ok_in;
   logic [31:0] gen_ff, gen_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] hcrc_ff, hcrc_in;
   logic [31:0] crc_next;
   logic [1:0]  lane;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (absrc_pkg::CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

   assign lane     = byte_count_ff[1:0];
   assign crc_next = crc_byte(crc_ff, data_byte);

   always_comb begin
      magic_ok_in = magic_ok_ff;
      gen_in      = gen_ff;
      len_in      = len_ff;
      hcrc_in     = hcrc_ff;
      crc_in      = crc_ff;
      priority if (byte_count_ff < absrc_pkg::COUNT_W'(4)) begin
         if (data_byte != absrc_pkg::MAGIC[lane]) begin
            magic_ok_in = 1'b0;
         end
      end else if (byte_count_ff < absrc_pkg::COUNT_W'(8)) begin
         gen_in[lane*8 +: 8] = data_byte;
      end else if (byte_count_ff < absrc_pkg::COUNT_W'(12)) begin
         len_in[lane*8 +: 8] = data_byte;
      end else if (byte_count_ff < absrc_pkg::COUNT_W'(absrc_pkg::HEADER_BYTES)) begin
         hcrc_in[lane*8 +: 8] = data_byte;
      end else begin
         crc_in = crc_next;
      end
      if (byte_count_ff == absrc_pkg::COUNT_MAX) begin
         byte_count_in = byte_count_ff;
      end else begin
         byte_count_in = byte_count_ff + absrc_pkg::COUNT_W'(1);
      end
   end

   always_comb begin
      entry.is_restart = (cmd == absrc_pkg::CMD_RESTART);
      entry.slot       = slot_select;
      entry.magic_ok   = magic_ok_in;
      entry.total      = byte_count_in;
      entry.hdr_gen    = gen_in;
      entry.hdr_len    = len_in;
      entry.hdr_crc    = hcrc_in;
      entry.crc        = crc_in;
   end

   assign push = accept && ((cmd == absrc_pkg::CMD_RESTART) || last_byte);

   always_ff @(posedge clock) begin
      if (reset || (accept && ((cmd == absrc_pkg::CMD_RESTART) || last_byte))) begin
         byte_count_ff <= '0;
         crc_ff        <= absrc_pkg::CRC_INIT;
         magic_ok_ff   <= 1'b1;
         gen_ff        <= '0;
         len_ff        <= '0;
         hcrc_ff       <= '0;
      end else if (accept) begin
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         magic_ok_ff   <= magic_ok_in;
         gen_ff        <= gen_in;
         len_ff        <= len_in;
         hcrc_ff       <= hcrc_in;
      end
   end

   // A finished record always leaves the front ready for a fresh header.
   a_count_restarts: assert property (@(posedge clock) disable iff (reset)
      push |=> (byte_count_ff == '0) && magic_ok_ff && (crc_ff == absrc_pkg::CRC_INIT))
      else $error("front state not restarted after a record or restart");

endmodule

### rtl/absrc_queue.sv
// Short FIFO of record entries between the front and the back end.
// Depends on absrc_pkg for the entry type and depth.
`timescale 1ns / 1ps

module absrc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  absrc_pkg::rec_entry_type  push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      not_empty,
   output absrc_pkg::rec_entry_type  head
);

   localparam int DEPTH = absrc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   absrc_pkg::rec_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("record queue holds more than its depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("record queue popped while empty");

endmodule

### rtl/absrc_back.sv
// Back end: judges each record, updates the A/B slot marks and drives the
// result register. Depends on absrc_pkg for the entry type and constants.
`timescale 1ns / 1ps

module absrc_back #(
   parameter int MAX_PAYLOAD = absrc_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_not_empty,
   input  absrc_pkg::rec_entry_type            q_head,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [absrc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int CW = absrc_pkg::COUNT_W;
   localparam logic [CW-1:0] TOTAL_MIN = CW'(absrc_pkg::HEADER_BYTES);
   localparam logic [CW-1:0] TOTAL_MAX = CW'(absrc_pkg::HEADER_BYTES + MAX_PAYLOAD);

   logic        slot_valid_ff [2];
   logic [31:0] slot_gen_ff   [2];
   logic        new_valid     [2];
   logic [31:0] new_gen       [2];

   logic        rsp_valid_ff;
   logic [absrc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CW-1:0] payload_len;
   logic          rec_valid;
   logic [31:0]   rec_gen;
   logic          any_valid;
   logic          latest_slot;
   logic [31:0]   latest_gen;
   logic          out_free;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign q_pop       = q_not_empty && (q_head.is_restart || out_free);
   assign payload_len = q_head.total - TOTAL_MIN;

   always_comb begin
      rec_valid = q_head.magic_ok
               && (q_head.total >= TOTAL_MIN)
               && (q_head.total <= TOTAL_MAX)
               && (q_head.hdr_len == {{(32-CW){1'b0}}, payload_len})
               && (~q_head.crc == q_head.hdr_crc);
      rec_gen = rec_valid ? q_head.hdr_gen : 32'd0;

      new_valid[0] = slot_valid_ff[0];
      new_valid[1] = slot_valid_ff[1];
      new_gen[0]   = slot_gen_ff[0];
      new_gen[1]   = slot_gen_ff[1];
      new_valid[q_head.slot] = rec_valid;
      new_gen[q_head.slot]   = rec_gen;

      any_valid = new_valid[0] || new_valid[1];
      // B wins only when it is strictly newer, or when A is not valid.
      priority if (new_valid[1] && (!new_valid[0] || (new_gen[1] > new_gen[0]))) begin
         latest_slot = 1'b1;
         latest_gen  = new_gen[1];
      end else if (new_valid[0]) begin
         latest_slot = 1'b0;
         latest_gen  = new_gen[0];
      end else begin
         latest_slot = 1'b0;
         latest_gen  = 32'd0;
      end

      rsp_data_in = {5'd0, latest_gen, latest_slot, any_valid, rec_gen, rec_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff[0] <= 1'b0;
         slot_valid_ff[1] <= 1'b0;
         slot_gen_ff[0]   <= '0;
         slot_gen_ff[1]   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (q_pop && q_head.is_restart) begin
            slot_valid_ff[0] <= 1'b0;
            slot_valid_ff[1] <= 1'b0;
            slot_gen_ff[0]   <= '0;
            slot_gen_ff[1]   <= '0;
         end else if (q_pop) begin
            slot_valid_ff[0] <= new_valid[0];
            slot_valid_ff[1] <= new_valid[1];
            slot_gen_ff[0]   <= new_gen[0];
            slot_gen_ff[1]   <= new_gen[1];
         end
         if (q_pop && !q_head.is_restart) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && !q_head.is_restart) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.is_restart) |=> !slot_valid_ff[0] && !slot_valid_ff[1])
      else $error("restart did not clear the slot marks");

   a_invalid_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (slot_valid_ff[0] || slot_gen_ff[0] == 32'd0)
      && (slot_valid_ff[1] || slot_gen_ff[1] == 32'd0))
      else $error("invalid slot keeps a nonzero generation");

   a_none_valid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[33]) |-> (rsp_data_ff[66:34] == 33'd0))
      else $error("no valid slot but a latest generation or slot is reported");

endmodule

### rtl/ab_snapshot_record_checker.sv
// Top level of the A/B snapshot record checker.
// Instantiates absrc_front, absrc_queue and absrc_back; uses absrc_pkg.
`timescale 1ns / 1ps

// Usage:
// Record words enter on the req_ channel, one byte per word. req_tuser[0] is
// the command (record byte or restart), req_tuser[1] the slot (A = 0, B = 1),
// and req_tlast marks the last byte of a record. A word is taken whenever
// req_tvalid and req_tready are both high.
// The front end takes one byte per cycle while req_tready is high; the
// byte-wide CRC-32 update and the header capture each finish in the cycle
// the byte is accepted. For each last byte one result word leaves on the
// rsp_ channel; a restart clears both slot marks and gives no result.
// rsp_tvalid rises once the queue has taken the entry at the accepting edge
// and the back end's result register has loaded it. With a ready receiver
// the back end hands out one result word per cycle.
// When the receiver stalls, the result register holds its word and the
// two-entry record queue fills; req_tready drops only once the queue is full,
// so bytes keep flowing at one per cycle until two finished records wait
// behind the held result. Reset clears both slot marks, empties the queue and
// restarts the header parser; no clearing pass is needed.

module ab_snapshot_record_checker #(
   parameter int MAX_PAYLOAD = absrc_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // data_byte[7:0]
   input  logic [absrc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd[0], slot_select[1]
   input  logic [absrc_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // record_valid[0], record_generation[32:1], any_valid[33],
   // latest_slot[34], latest_generation[66:35], zero fill[71:67]
   output logic [absrc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   logic                     accept;
   logic                     push;
   logic                     full;
   logic                     pop;
   logic                     not_empty;
   absrc_pkg::rec_entry_type push_entry;
   absrc_pkg::rec_entry_type head;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   absrc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_tuser[0]),
      .data_byte   (req_tdata),
      .slot_select (req_tuser[1]),
      .last_byte   (req_tlast),
      .push        (push),
      .entry       (push_entry)
   );

   absrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   absrc_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (not_empty),
      .q_head      (head),
      .q_pop       (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

### verif/tb_ab_snapshot_record_checker.sv
// Self-checking testbench of ab_snapshot_record_checker: record words go in on req_,
// verdicts are predicted in the bench and compared with each word on rsp_.
// Depends on absrc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_ab_snapshot_record_checker;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int LONG_HOLD    = 400;
   localparam int TAIL_CYCLES  = 20;
   localparam int RANDOM_WORDS = 600;
   localparam int MAX_PAYLOAD  = absrc_pkg::MAX_PAYLOAD_DEFAULT;
   localparam logic SLOT_A = 1'b0;
   localparam logic SLOT_B = 1'b1;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_type;
   typedef enum int {
      FAULT_MAGIC, FAULT_LENGTH, FAULT_CRC, FAULT_TRUNCATE, FAULT_EXTRA, FAULT_NOISE,
      FAULT_ABORT
   } fault_type;

   typedef struct {
      logic        ok;
      logic [31:0] gen;
      logic        any;
      logic        latest;
      logic [31:0] latest_gen;
   } verdict_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [absrc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [absrc_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic                             req_tlast = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [absrc_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // Bench copy of the record parser and of the two slot marks.
   logic [absrc_pkg::COUNT_W-1:0] rx_count;
   logic [31:0]        rx_crc;
   logic               rx_magic_ok;
   logic [31:0]        rx_gen;
   logic [31:0]        rx_len;
   logic [31:0]        rx_crc_field;
   logic               slot_ok [2];
   logic [31:0]        slot_gen [2];

   verdict_type expected_verdicts [$];
   logic [7:0]  rec_bytes [$];
   int          mismatch_count = 0;
   int          words_sent = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   bit          steady_sender = 1'b0;
   bit          hold_off_pending = 1'b0;
   int          hold_left = 0;
   int          pattern_left = 0;
   rx_mode_type rx_mode = RX_ALWAYS;

   ab_snapshot_record_checker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ab_snapshot_record_checker test failed");
         $finish;
      end
   end

   function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      c ^= {24'd0, b};
      for (int i = 0; i < 8; i++)
         c = (c >> 1) ^ (c[0] ? absrc_pkg::CRC_POLY : 32'd0);
      return c;
   endfunction

   function automatic void clear_record_state();
      rx_count     = '0;
      rx_crc       = absrc_pkg::CRC_INIT;
      rx_magic_ok  = 1'b1;
      rx_gen       = '0;
      rx_len       = '0;
      rx_crc_field = '0;
   endfunction

   // Updates the bench state with one accepted word and queues the verdict it causes.
   function automatic void predict_verdict(logic cmd, logic [7:0] b, logic slot, logic last);
      int          idx;
      int          total;
      verdict_type v;
      words_sent++;
      if (cmd == absrc_pkg::CMD_RESTART) begin
         clear_record_state();
         slot_ok  = '{1'b0, 1'b0};
         slot_gen = '{32'd0, 32'd0};
         return;
      end
      idx = int'(rx_count);
      if (idx < 4) begin
         if (b != absrc_pkg::MAGIC[idx])
            rx_magic_ok = 1'b0;
      end else if (idx < 8) begin
         rx_gen[(idx - 4) * 8 +: 8] = b;
      end else if (idx < 12) begin
         rx_len[(idx - 8) * 8 +: 8] = b;
      end else if (idx < absrc_pkg::HEADER_BYTES) begin
         rx_crc_field[(idx - 12) * 8 +: 8] = b;
      end else begin
         rx_crc = crc_step(rx_crc, b);
      end
      if (rx_count != absrc_pkg::COUNT_MAX)
         rx_count++;
      if (!last)
         return;

      total = int'(rx_count);
      v.ok = rx_magic_ok && total >= absrc_pkg::HEADER_BYTES
             && total <= absrc_pkg::HEADER_BYTES + MAX_PAYLOAD
             && rx_len == 32'(total - absrc_pkg::HEADER_BYTES) && ~rx_crc == rx_crc_field;
      v.gen = v.ok ? rx_gen : 32'd0;
      slot_ok[slot]  = v.ok;
      slot_gen[slot] = v.gen;
      v.any = slot_ok[SLOT_A] || slot_ok[SLOT_B];
      // Slot B wins only when it is valid and strictly newer than slot A, or when slot A is not valid.
      if (slot_ok[SLOT_B] && (!slot_ok[SLOT_A] || slot_gen[SLOT_B] > slot_gen[SLOT_A])) begin
         v.latest     = SLOT_B;
         v.latest_gen = slot_gen[SLOT_B];
      end else begin
         v.latest     = SLOT_A;
         v.latest_gen = slot_ok[SLOT_A] ? slot_gen[SLOT_A] : 32'd0;
      end
      expected_verdicts.push_back(v);
      clear_record_state();
   endfunction

   function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
   endfunction

   always @(posedge clock) begin : result_check
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            note_mismatch("unexpected result word, record_generation", 32'd0, rsp_tdata[32:1]);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_tdata[0] !== want.ok)
               note_mismatch("record_valid", 32'(want.ok), 32'(rsp_tdata[0]));
            if (rsp_tdata[32:1] !== want.gen)
               note_mismatch("record_generation", want.gen, rsp_tdata[32:1]);
            if (rsp_tdata[33] !== want.any)
               note_mismatch("any_valid", 32'(want.any), 32'(rsp_tdata[33]));
            if (rsp_tdata[34] !== want.latest)
               note_mismatch("latest_slot", 32'(want.latest), 32'(rsp_tdata[34]));
            if (rsp_tdata[66:35] !== want.latest_gen)
               note_mismatch("latest_generation", want.latest_gen, rsp_tdata[66:35]);
         end
      end
   end

   // Receiver: picks a new stall pattern each time the pattern_left countdown runs out, and holds off for a
   // long stretch when the back-pressure test asks for it.
   always @(posedge clock) begin
      if (hold_off_pending) begin
         hold_off_pending = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (pattern_left == 0) begin
         pattern_left = $urandom_range(16, 96);
         rx_mode = rx_mode_type'($urandom_range(0, 3));
      end
      pattern_left--;
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         unique case (rx_mode)
            RX_ALWAYS: rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: rsp_tready <= ($urandom_range(0, 7) != 0);
            default:   rsp_tready <= (pattern_left % 4 != 0);
         endcase
      end
   end

   // Offers one word and returns once it has been taken; gaps come between bursts.
   task automatic send_word(logic cmd, logic [7:0] b, logic slot, logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {slot, cmd};
      req_tlast  <= last;
      do
         @(posedge clock);
      while (!req_tready);
      predict_verdict(cmd, b, slot, last);
   endtask

   task automatic send_restart();
      send_word(absrc_pkg::CMD_RESTART, 8'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // Sends the first n bytes of rec_bytes; with mixed tags only the last byte
   // carries the intended slot.
   task automatic send_bytes(logic slot, bit mixed, int n, bit with_last);
      logic tag;
      for (int i = 0; i < n; i++) begin
         tag = (mixed && i != n - 1) ? 1'($urandom) : slot;
         send_word(absrc_pkg::CMD_RECORD, rec_bytes[i], tag, with_last && i == n - 1);
      end
   endtask

   task automatic send_record(logic slot);
      send_bytes(slot, 1'b0, rec_bytes.size(), 1'b1);
   endtask

   function automatic void build_good(logic [31:0] gen, int plen);
      logic [31:0] c;
      c = absrc_pkg::CRC_INIT;
      rec_bytes.delete();
      for (int i = 0; i < 4; i++) rec_bytes.push_back(absrc_pkg::MAGIC[i]);
      for (int i = 0; i < 4; i++) rec_bytes.push_back(gen[8 * i +: 8]);
      for (int i = 0; i < 4; i++) rec_bytes.push_back(8'(plen >> (8 * i)));
      for (int i = 0; i < 4; i++) rec_bytes.push_back(8'h00);
      for (int i = 0; i < plen; i++) begin
         rec_bytes.push_back(8'($urandom));
         c = crc_step(c, rec_bytes[absrc_pkg::HEADER_BYTES + i]);
      end
      c = ~c;
      for (int i = 0; i < 4; i++) rec_bytes[12 + i] = c[8 * i +: 8];
   endfunction

   function automatic void set_len_field(logic [31:0] v);
      for (int i = 0; i < 4; i++) rec_bytes[8 + i] = v[8 * i +: 8];
   endfunction

   function automatic logic [31:0] pick_gen();
      // Small generations make ties between the slots common.
      return ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 3)) : 32'($urandom);
   endfunction

   function automatic int pick_plen();
      return ($urandom_range(0, 39) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
   endfunction

   task automatic test_slot_choice();
      build_good(32'd5, 8);            send_record(SLOT_A);
      build_good(32'd7, 3);            send_record(SLOT_B);
      build_good(32'd7, 0);            send_record(SLOT_A);
      build_good(32'hffffffff, 20);    send_record(SLOT_B);
      build_good(32'd0, 1);            send_record(SLOT_A);
   endtask

   task automatic test_header_checks();
      build_good(32'd11, 6);  rec_bytes[0] ^= 8'h01;  send_record(SLOT_B);
      build_good(32'd12, 6);  rec_bytes[3] ^= 8'h80;  send_record(SLOT_A);
      build_good(32'd13, 5);  set_len_field(32'd6);   send_record(SLOT_A);
      build_good(32'd14, 5);  set_len_field(32'd4);   send_record(SLOT_B);
      build_good(32'd15, 9);  rec_bytes[15] ^= 8'h80; send_record(SLOT_A);
      build_good(32'd16, 9);  rec_bytes[20] ^= 8'h10; send_record(SLOT_B);
      // Records that end inside the header.
      build_good(32'd17, 0);  send_bytes(SLOT_A, 1'b0, 1, 1'b1);
      build_good(32'd18, 0);  send_bytes(SLOT_B, 1'b0, 15, 1'b1);
   endtask

   task automatic test_length_bounds();
      // A bare header with an empty payload is the shortest valid record.
      build_good(32'h8000_0001, 0);
      send_record(SLOT_A);
      // The length field must match in all 32 bits, not only in the low ones.
      build_good(32'h8000_0002, 2);
      set_len_field(32'h0001_0002);
      send_record(SLOT_B);
      build_good(32'h8000_0003, 4);
      set_len_field(32'(MAX_PAYLOAD));
      send_record(SLOT_B);
   endtask

   task automatic test_restart();
      build_good(32'd9, 4);  send_record(SLOT_A);
      send_restart();
      build_good(32'd9, 4);  rec_bytes[1] = 8'h00;  send_record(SLOT_B);
      build_good(32'd3, 12);
      send_bytes(SLOT_B, 1'b0, 10, 1'b0);
      send_restart();
      send_record(SLOT_A);
   endtask

   task automatic test_mixed_tags();
      build_good(32'd40, 10);  send_bytes(SLOT_B, 1'b1, rec_bytes.size(), 1'b1);
      build_good(32'd41, 10);  send_bytes(SLOT_A, 1'b1, rec_bytes.size(), 1'b1);
   endtask

   task automatic test_back_pressure();
      steady_sender = 1'b1;
      hold_off_pending = 1'b1;
      for (int i = 0; i < 10; i++) begin
         build_good(pick_gen(), $urandom_range(0, 8));
         send_record(1'($urandom));
      end
      steady_sender = 1'b0;
   endtask

   task automatic test_random_records();
      int        first_word;
      int        n;
      logic      slot;
      fault_type fault;
      first_word = words_sent;
      while (words_sent - first_word < RANDOM_WORDS) begin
         slot = 1'($urandom);
         n = $urandom_range(0, 99);
         if (n < 5) begin
            send_restart();
         end else if (n < 70) begin
            build_good(pick_gen(), pick_plen());
            send_bytes(slot, $urandom_range(0, 9) == 0, rec_bytes.size(), 1'b1);
         end else begin
            build_good(pick_gen(), pick_plen());
            fault = fault_type'($urandom_range(0, 6));
            unique case (fault)
               FAULT_MAGIC:  rec_bytes[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
               FAULT_LENGTH: set_len_field(32'(rec_bytes.size() - absrc_pkg::HEADER_BYTES)
                                           + 32'($urandom_range(1, 3)) * 32'hffff_fffe);
               FAULT_CRC:    rec_bytes[$urandom_range(12, rec_bytes.size() - 1)] ^=
                                8'(1 << $urandom_range(0, 7));
               FAULT_EXTRA:  repeat ($urandom_range(1, 8)) rec_bytes.push_back(8'($urandom));
               FAULT_NOISE: begin
                  rec_bytes.delete();
                  repeat ($urandom_range(1, 40)) rec_bytes.push_back(8'($urandom));
               end
               default: ;
            endcase
            if (fault == FAULT_TRUNCATE) begin
               send_bytes(slot, 1'b0, $urandom_range(1, rec_bytes.size() - 1), 1'b1);
            end else if (fault == FAULT_ABORT) begin
               send_bytes(slot, 1'b0, $urandom_range(1, rec_bytes.size() - 1), 1'b0);
               send_restart();
            end else begin
               send_record(slot);
            end
         end
      end
   endtask

   initial begin
      clear_record_state();
      slot_ok  = '{1'b0, 1'b0};
      slot_gen = '{32'd0, 32'd0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_slot_choice();
      test_header_checks();
      test_length_bounds();
      test_restart();
      test_mixed_tags();
      test_back_pressure();
      test_random_records();

      req_tvalid <= 1'b0;
      while (expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
         $display("ab_snapshot_record_checker test passed");
      end else begin
         $display("ab_snapshot_record_checker test failed");
      end
      $finish;
   end

endmodule
